@@ hw/rtl/pcslt_pkg.sv @@
// ----------------------------------------------------------------------------
// pcslt_pkg: shared types and codes for the per-CPU TLB
// Holds the request, response, configuration and internal operation types.
// ----------------------------------------------------------------------------
package pcslt_pkg;

	// Request kinds on the input channel.
	localparam logic REQ_ACCESS = 1'b0;
	localparam logic REQ_INVAL  = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_SETB   = 2'd1;
	localparam logic [1:0] CFG_WAYS   = 2'd2;
	localparam logic [1:0] CFG_CPUS   = 2'd3;

	// Operation kinds decided by the front end.
	localparam logic [1:0] K_ZERO = 2'd0;
	localparam logic [1:0] K_BAD  = 2'd1;
	localparam logic [1:0] K_ACC  = 2'd2;
	localparam logic [1:0] K_INV  = 2'd3;

	typedef struct packed {
		logic        req_type;
		logic [1:0]  cpu;
		logic [47:0] page;
	} pcslt_req_t;

	typedef struct packed {
		logic       hit;
		logic       bad_cpu;
		logic [2:0] invalidated_count;
	} pcslt_rsp_t;

	// Effective configuration after clamping.
	typedef struct packed {
		logic       en;
		logic [3:0] setb;
		logic [4:0] nw;
		logic [4:0] nc;
	} pcslt_cfg_t;

	// Classified operation passed from front to back.
	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  cpu;
		logic [11:0] set;
		logic [47:0] page;
	} pcslt_op_t;

endpackage

@@ hw/rtl/pcslt_ram.sv @@
// ----------------------------------------------------------------------------
// pcslt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pcslt_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                      wdata,
	input  logic                              re,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                      rdata
);

	logic [W-1:0] mem [D];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/pcslt_front.sv @@
// ----------------------------------------------------------------------------
// pcslt_front: request classification and operation queue
// Decodes each accepted request into an operation and queues it for the back end.
// ----------------------------------------------------------------------------
module pcslt_front
	import pcslt_pkg::*;
#(
	parameter int PAGE_BITS = 48
) (
	input  logic       clk,
	input  logic       arst_n,
	input  pcslt_cfg_t cfg,
	input  logic       push,
	input  pcslt_req_t req,
	output logic       full,
	output logic       op_valid,
	output pcslt_op_t  op,
	input  logic       pop
);

	localparam int PW = (PAGE_BITS < 48) ? PAGE_BITS : 48;
	localparam logic [47:0] PMASK = (PW >= 48) ? {48{1'b1}} : ((48'd1 << PW) - 48'd1);

	pcslt_op_t       cls;
	pcslt_op_t       ent_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;
	logic [47:0]     pg;

	// Classify the incoming request.
	always_comb begin
		pg       = req.page & PMASK;
		cls.page = pg;
		cls.cpu  = {2'b00, req.cpu};
		cls.set  = pg[11:0] & ~(12'hFFF << cfg.setb);
		if (!cfg.en) begin
			cls.kind = K_ZERO;
		end else if (req.req_type == REQ_INVAL) begin
			cls.kind = K_INV;
		end else if ({3'b000, req.cpu} >= cfg.nc) begin
			cls.kind = K_BAD;
		end else begin
			cls.kind = K_ACC;
		end
	end

	// Two-entry queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cls;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign full     = (cnt_q == 2'd2);
	assign op_valid = (cnt_q != 2'd0);
	assign op       = ent_q[rp_q];

endmodule

@@ hw/rtl/pcslt_back.sv @@
// ----------------------------------------------------------------------------
// pcslt_back: TLB set update engine
// Reads one CPU set row, applies lookup, fill, LRU and shootdown, and writes it back.
// ----------------------------------------------------------------------------
module pcslt_back
	import pcslt_pkg::*;
#(
	parameter int SETS      = 512,
	parameter int WAYS      = 4,
	parameter int CPUS      = 4,
	parameter int PAGE_BITS = 48
) (
	input  logic       clk,
	input  logic       arst_n,
	input  pcslt_cfg_t cfg,
	input  logic       op_valid,
	input  pcslt_op_t  op,
	output logic       pop,
	output logic       clearing,
	output logic       done,
	output pcslt_rsp_t rsp
);

	localparam int PW    = (PAGE_BITS < 48) ? PAGE_BITS : 48;
	localparam int RANKW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WIDX  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROWS  = CPUS * SETS;
	localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ROWW  = WAYS * (1 + PW + RANKW);
	localparam logic [RANKW-1:0] RANK_MAX = RANKW'(WAYS - 1);

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_UPD  = 2'd3;

	logic [1:0]       st_q;
	pcslt_op_t        op_q;
	logic [3:0]       ci_q;
	logic [2:0]       cnt_q;
	logic [AW-1:0]    clr_q;
	logic             done_q;
	pcslt_rsp_t       rsp_q;

	logic [3:0]       cpu_sel;
	logic [AW-1:0]    row_addr;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [ROWW-1:0]  wdata;
	logic [ROWW-1:0]  rdata;

	logic [WAYS-1:0]            v, nv;
	logic [WAYS-1:0][PW-1:0]    pg, npg;
	logic [WAYS-1:0][RANKW-1:0] rk, nrk;
	logic [WAYS-1:0]            inuse;
	logic                       found;
	logic [WIDX-1:0]            hw;
	logic                       has_inv;
	logic [WIDX-1:0]            inv_w;
	logic [WIDX-1:0]            max_w;
	logic [WIDX-1:0]            tw;
	logic [RANKW-1:0]           old;
	logic                       all_age;
	logic [2:0]                 cnt_n;
	logic                       last_cpu;

	// Row address of the selected CPU and set.
	always_comb begin
		cpu_sel  = (op_q.kind == K_INV) ? ci_q : op_q.cpu;
		row_addr = AW'(cpu_sel) * AW'(SETS) + AW'(op_q.set);
	end

	assign pop      = (st_q == ST_IDLE) && op_valid;
	assign clearing = (st_q == ST_CLR);
	assign {v, pg, rk} = rdata;

	// Lookup, victim choice and rank update on the row read.
	always_comb begin
		nv      = v;
		npg     = pg;
		nrk     = rk;
		found   = 1'b0;
		hw      = '0;
		has_inv = 1'b0;
		inv_w   = '0;
		max_w   = '0;
		for (int w = 0; w < WAYS; w++) begin
			inuse[w] = (5'(w) < cfg.nw);
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (inuse[w] && v[w] && pg[w] == op_q.page[PW-1:0]) begin
				found = 1'b1;
				hw    = WIDX'(w);
			end
			if (inuse[w] && !v[w]) begin
				has_inv = 1'b1;
				inv_w   = WIDX'(w);
			end
		end
		for (int w = 1; w < WAYS; w++) begin
			if (inuse[w] && rk[w] > rk[max_w]) begin
				max_w = WIDX'(w);
			end
		end
		if (found) begin
			tw      = hw;
			all_age = 1'b0;
		end else if (has_inv) begin
			tw      = inv_w;
			all_age = 1'b1;
		end else begin
			tw      = max_w;
			all_age = 1'b0;
		end
		old = rk[tw];
		if (op_q.kind == K_INV) begin
			if (found) begin
				nv[hw] = 1'b0;
				for (int i = 0; i < WAYS; i++) begin
					if (inuse[i] && i != int'(hw) && v[i] && rk[i] > rk[hw]) begin
						nrk[i] = rk[i] - RANKW'(1);
					end
				end
			end
		end else begin
			for (int i = 0; i < WAYS; i++) begin
				if (inuse[i] && i != int'(tw) && v[i] && (all_age || rk[i] < old) &&
				    rk[i] != RANK_MAX) begin
					nrk[i] = rk[i] + RANKW'(1);
				end
			end
			nrk[tw] = '0;
			nv[tw]  = 1'b1;
			npg[tw] = op_q.page[PW-1:0];
		end
		cnt_n    = (found && cnt_q != 3'd7) ? cnt_q + 3'd1 : cnt_q;
		last_cpu = ({1'b0, ci_q} + 5'd1 == cfg.nc);
	end

	// Memory write port: clearing pass or row write-back.
	always_comb begin
		we    = (st_q == ST_CLR) || (st_q == ST_UPD);
		waddr = (st_q == ST_CLR) ? clr_q : row_addr;
		wdata = (st_q == ST_CLR) ? '0 : {nv, npg, nrk};
	end

	pcslt_ram #(
		.W (ROWW),
		.D (ROWS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (st_q == ST_RD),
		.raddr (row_addr),
		.rdata (rdata)
	);

	// Operation payload register.
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= op;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLR;
			clr_q  <= '0;
			ci_q   <= 4'd0;
			cnt_q  <= 3'd0;
			done_q <= 1'b0;
			rsp_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				ST_CLR: begin
					if (clr_q == AW'(ROWS - 1)) begin
						st_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (pop) begin
						ci_q  <= 4'd0;
						cnt_q <= 3'd0;
						if (op.kind == K_ZERO || op.kind == K_BAD) begin
							done_q <= 1'b1;
							rsp_q  <= '{hit: 1'b0, bad_cpu: (op.kind == K_BAD),
								invalidated_count: 3'd0};
						end else begin
							st_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					st_q <= ST_UPD;
				end
				ST_UPD: begin
					if (op_q.kind == K_INV) begin
						cnt_q <= cnt_n;
						if (last_cpu) begin
							done_q <= 1'b1;
							rsp_q  <= '{hit: 1'b0, bad_cpu: 1'b0, invalidated_count: cnt_n};
							st_q   <= ST_IDLE;
						end else begin
							ci_q <= ci_q + 4'd1;
							st_q <= ST_RD;
						end
					end else begin
						done_q <= 1'b1;
						rsp_q  <= '{hit: found, bad_cpu: 1'b0, invalidated_count: 3'd0};
						st_q   <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ hw/rtl/per_cpu_set_assoc_lru_tlb.sv @@
// A disabled or bad-CPU access is answered straight from idle; an access reads and updates
// its set row; an invalidate reads and updates the row of each CPU in use.
// The back end takes a new operation from the queue only when idle, so each set row is
// read, updated and written back through the row RAM before the next request starts.
// After reset a clearing pass zeroes the row RAM; busy is high then.
// Results are shown for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// per_cpu_set_assoc_lru_tlb: per-CPU set-associative TLB with LRU and shootdown
// Front end classifies requests into a queue; back end updates one set row at a time.
// ----------------------------------------------------------------------------
module per_cpu_set_assoc_lru_tlb
	import pcslt_pkg::*;
#(
	parameter int SETS      = 512,
	parameter int WAYS      = 4,
	parameter int CPUS      = 4,
	parameter int PAGE_BITS = 48
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  pcslt_req_t req,
	output logic       done,
	output pcslt_rsp_t rsp,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [3:0] cfg_wdata
);

	localparam int SB = $clog2(SETS + 1) - 1;

	logic       en_q;
	logic [3:0] setb_q;
	logic [2:0] ways_q;
	logic [2:0] cpus_q;
	pcslt_cfg_t cfg;
	logic       full;
	logic       clearing;
	logic       op_valid;
	pcslt_op_t  op;
	logic       pop;
	logic       push;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b1;
			setb_q <= 4'd9;
			ways_q <= 3'd4;
			cpus_q <= 3'd4;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ENABLE: en_q   <= cfg_wdata[0];
				CFG_SETB:   setb_q <= cfg_wdata;
				CFG_WAYS:   ways_q <= cfg_wdata[2:0];
				CFG_CPUS:   cpus_q <= cfg_wdata[2:0];
				default:    en_q   <= en_q;
			endcase
		end
	end

	// Clamp the configuration to the built sizes.
	always_comb begin
		cfg.en   = en_q;
		cfg.setb = (setb_q > 4'(SB)) ? 4'(SB) : setb_q;
		if (ways_q == 3'd0) begin
			cfg.nw = 5'd1;
		end else if ({2'b00, ways_q} > 5'(WAYS)) begin
			cfg.nw = 5'(WAYS);
		end else begin
			cfg.nw = {2'b00, ways_q};
		end
		if (cpus_q == 3'd0) begin
			cfg.nc = 5'd1;
		end else if ({2'b00, cpus_q} > 5'(CPUS)) begin
			cfg.nc = 5'(CPUS);
		end else begin
			cfg.nc = {2'b00, cpus_q};
		end
	end

	assign busy = full || clearing;
	assign push = start && !busy;

	pcslt_front #(
		.PAGE_BITS (PAGE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.push     (push),
		.req      (req),
		.full     (full),
		.op_valid (op_valid),
		.op       (op),
		.pop      (pop)
	);

	pcslt_back #(
		.SETS      (SETS),
		.WAYS      (WAYS),
		.CPUS      (CPUS),
		.PAGE_BITS (PAGE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.op_valid (op_valid),
		.op       (op),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.rsp      (rsp)
	);

	// A result never reports both a hit and a bad CPU.
	a_hit_bad: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.hit && rsp.bad_cpu))
		else $error("hit and bad_cpu both set");

	// A shootdown count comes with no access flags.
	a_inv_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.invalidated_count != 3'd0) |-> (!rsp.hit && !rsp.bad_cpu))
		else $error("invalidate result carries access flags");

	// No result is produced while the clearing pass runs.
	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$past(clearing) |-> !done)
		else $error("result during clearing pass");

	// Nothing is popped from the queue while the clearing pass runs.
	a_clr_pop: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop)
		else $error("queue popped during clearing pass");

endmodule

@@ verif/tb_per_cpu_set_assoc_lru_tlb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_cpu_set_assoc_lru_tlb: self-checking bench for the per-CPU LRU TLB
// Drives accesses and shootdowns in bursts over several configurations and
// checks each response against a behavioral model of the TLB state.
// ----------------------------------------------------------------------------
module tb_per_cpu_set_assoc_lru_tlb;
	import pcslt_pkg::*;

	localparam int SETS = 512;
	localparam int WAYS = 4;
	localparam int CPUS = 4;
	localparam int NENT = CPUS * SETS * WAYS;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	pcslt_req_t req = '0;
	logic done;
	pcslt_rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_idx = CFG_ENABLE;
	logic [3:0] cfg_wdata = '0;

	per_cpu_set_assoc_lru_tlb dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// Model state of all TLB entries and the live register values.
	bit tlb_valid[NENT];
	logic [47:0] tlb_page[NENT];
	logic [1:0] tlb_rank[NENT];
	bit m_en;
	logic [3:0] m_setb;
	logic [2:0] m_ways;
	logic [2:0] m_cpus;

	pcslt_req_t pending_reqs[$];
	pcslt_rsp_t expected_rsps[$];
	int errors = 0;
	int cycles = 0;
	bit feeding_done = 1'b0;

	// Make way w most recent; valid ways younger than old age by one.
	function automatic void promote(int base, int nw, int w, int old);
		for (int i = 0; i < nw; i++)
			if (i != w && tlb_valid[base+i] && tlb_rank[base+i] < old &&
			    tlb_rank[base+i] < WAYS - 1)
				tlb_rank[base+i]++;
		tlb_rank[base+w] = '0;
	endfunction

	// Apply one request to the model and return the response it should give.
	function automatic pcslt_rsp_t tlb_lookup(pcslt_req_t r);
		pcslt_rsp_t o;
		int nw, nc, b, set, base, victim;
		bit found;
		o = '0;
		nw = (m_ways == 0) ? 1 : (m_ways > WAYS ? WAYS : m_ways);
		nc = (m_cpus == 0) ? 1 : (m_cpus > CPUS ? CPUS : m_cpus);
		b = m_setb;
		while (b > 0 && (1 << b) > SETS) b--;
		set = int'(r.page[15:0]) & ((1 << b) - 1);
		if (r.req_type == REQ_ACCESS) begin
			if (m_en && r.cpu >= nc) begin
				o.bad_cpu = 1'b1;
			end else if (m_en) begin
				base = (r.cpu * SETS + set) * WAYS;
				found = 1'b0;
				for (int w = 0; w < nw && !found; w++)
					if (tlb_valid[base+w] && tlb_page[base+w] == r.page) begin
						promote(base, nw, w, tlb_rank[base+w]);
						found = 1'b1;
					end
				if (found) begin
					o.hit = 1'b1;
				end else begin
					victim = nw;
					for (int w = 0; w < nw; w++)
						if (!tlb_valid[base+w]) begin
							victim = w;
							break;
						end
					if (victim < nw) begin
						promote(base, nw, victim, 255);
					end else begin
						victim = 0;
						for (int w = 1; w < nw; w++)
							if (tlb_rank[base+w] > tlb_rank[base+victim]) victim = w;
						promote(base, nw, victim, tlb_rank[base+victim]);
					end
					tlb_valid[base+victim] = 1'b1;
					tlb_page[base+victim] = r.page;
				end
			end
		end else if (m_en) begin
			for (int c = 0; c < nc; c++) begin
				base = (c * SETS + set) * WAYS;
				for (int w = 0; w < nw; w++)
					if (tlb_valid[base+w] && tlb_page[base+w] == r.page) begin
						tlb_valid[base+w] = 1'b0;
						for (int i = 0; i < nw; i++)
							if (tlb_valid[base+i] && tlb_rank[base+i] > tlb_rank[base+w])
								tlb_rank[base+i]--;
						if (o.invalidated_count < 7) o.invalidated_count++;
						break;
					end
			end
		end
		return o;
	endfunction

	// Acceptance tracking at the rising edge; the model is updated on transfer.
	bit taken_q = 1'b0;
	always @(posedge clk) begin
		taken_q <= start && !busy;
		if (start && !busy) expected_rsps.push_back(tlb_lookup(req));
	end

	// Driver: bursts of transfers with random gaps, changing at the falling edge.
	int gap_left = 0;
	int burst_left = 0;
	always @(negedge clk) begin
		if (arst_n && (!start || taken_q)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				req <= pending_reqs.pop_front();
				start <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
				end else begin
					burst_left--;
					if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 :
						$urandom_range(1, 8);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every done strobe is a response transfer.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (done) begin
			if (expected_rsps.size() == 0) begin
				$error("response with nothing expected");
				errors++;
			end else begin
				pcslt_rsp_t e;
				e = expected_rsps.pop_front();
				if (rsp.hit !== e.hit) begin
					$error("hit: expected %0d, got %0d", e.hit, rsp.hit);
					errors++;
				end
				if (rsp.bad_cpu !== e.bad_cpu) begin
					$error("bad_cpu: expected %0d, got %0d", e.bad_cpu, rsp.bad_cpu);
					errors++;
				end
				if (rsp.invalidated_count !== e.invalidated_count) begin
					$error("invalidated_count: expected %0d, got %0d",
						e.invalidated_count, rsp.invalidated_count);
					errors++;
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic pcslt_req_t make_req(logic t, logic [1:0] c, logic [47:0] p);
		pcslt_req_t r;
		r.req_type = t;
		r.cpu = c;
		r.page = p;
		return r;
	endfunction

	function automatic logic [47:0] rand_page();
		logic [63:0] rv;
		rv = {$urandom(), $urandom()};
		return rv[47:0];
	endfunction

	// Wait for all queued requests to transfer and every response to arrive.
	task automatic drain();
		while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [3:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ENABLE: m_en = val[0];
			CFG_SETB: m_setb = val;
			CFG_WAYS: m_ways = val[2:0];
			default: m_cpus = val[2:0];
		endcase
	endtask

	// A phase: mostly reuse of a small working set so hits, evictions and
	// shootdowns are common, with occasional fully random pages.
	task automatic run_phase(int n);
		logic [47:0] pool[16];
		for (int i = 0; i < 16; i++)
			pool[i] = ($urandom_range(0, 3) == 0) ? rand_page() :
				{5'd0, 3'($urandom_range(0, 7)), 40'd0} |
				48'($urandom_range(0, 5) * SETS) | 48'($urandom_range(0, 3));
		for (int i = 0; i < n; i++)
			pending_reqs.push_back(make_req($urandom_range(0, 4) == 0 ? REQ_INVAL : REQ_ACCESS,
				2'($urandom_range(0, 3)),
				$urandom_range(0, 9) == 0 ? rand_page() : pool[$urandom_range(0, 15)]));
		drain();
	endtask

	initial begin
		m_en = 1'b1;
		m_setb = 4'd9;
		m_ways = 3'd4;
		m_cpus = 3'd4;
		for (int i = 0; i < NENT; i++) begin
			tlb_valid[i] = 1'b0;
			tlb_rank[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: fill one set past capacity, hit, evict, shoot down.
		for (int i = 0; i < 5; i++)
			pending_reqs.push_back(make_req(REQ_ACCESS, 2'd0, 48'd7 + i * SETS));
		pending_reqs.push_back(make_req(REQ_ACCESS, 2'd0, 48'd7 + 4 * SETS));
		pending_reqs.push_back(make_req(REQ_ACCESS, 2'd0, 48'd7 + 1 * SETS));
		pending_reqs.push_back(make_req(REQ_ACCESS, 2'd3, 48'd7 + 1 * SETS));
		pending_reqs.push_back(make_req(REQ_INVAL, 2'd2, 48'd7 + 1 * SETS));
		pending_reqs.push_back(make_req(REQ_INVAL, 2'd0, 48'd7 + 1 * SETS));
		pending_reqs.push_back(make_req(REQ_ACCESS, 2'd1, 48'hFFFF_FFFF_FFFF));
		pending_reqs.push_back(make_req(REQ_ACCESS, 2'd1, 48'hFFFF_FFFF_FFFF));
		pending_reqs.push_back(make_req(REQ_ACCESS, 2'd2, 48'd0));
		pending_reqs.push_back(make_req(REQ_INVAL, 2'd1, 48'hFFFF_FFFF_FFFF));
		drain();
		write_reg(CFG_CPUS, 4'd2);
		pending_reqs.push_back(make_req(REQ_ACCESS, 2'd3, 48'd5));
		pending_reqs.push_back(make_req(REQ_ACCESS, 2'd1, 48'd5));
		drain();
		write_reg(CFG_ENABLE, 4'd0);
		pending_reqs.push_back(make_req(REQ_ACCESS, 2'd1, 48'd5));
		pending_reqs.push_back(make_req(REQ_INVAL, 2'd0, 48'd5));
		drain();

		// Random phases across configurations, extremes among them.
		write_reg(CFG_ENABLE, 4'd1);
		write_reg(CFG_CPUS, 4'd4);
		run_phase(200);
		write_reg(CFG_SETB, 4'd0);
		write_reg(CFG_WAYS, 4'd1);
		run_phase(120);
		write_reg(CFG_SETB, 4'd15);
		write_reg(CFG_WAYS, 4'd7);
		write_reg(CFG_CPUS, 4'd0);
		run_phase(120);
		write_reg(CFG_SETB, 4'd2);
		write_reg(CFG_WAYS, 4'd0);
		write_reg(CFG_CPUS, 4'd7);
		run_phase(120);
		write_reg(CFG_WAYS, 4'd3);
		write_reg(CFG_CPUS, 4'd3);
		run_phase(150);
		write_reg(CFG_ENABLE, 4'd0);
		run_phase(40);
		write_reg(CFG_ENABLE, 4'd1);
		write_reg(CFG_SETB, 4'd9);
		write_reg(CFG_WAYS, 4'd4);
		write_reg(CFG_CPUS, 4'd4);
		run_phase(280);

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
